// ===== hdl/vcp_pkg.sv =====
// Package for the video chip CPU port: transaction types, item kinds and
// register constants. No dependencies.
`timescale 1ns / 1ps

package vcp_pkg;

    localparam int DEFAULT_MEMORY_BYTES = 16'h4000;

    // Item kinds.
    localparam logic [2:0] KIND_DATA_WRITE    = 3'd0;
    localparam logic [2:0] KIND_CONTROL_WRITE = 3'd1;
    localparam logic [2:0] KIND_DATA_READ     = 3'd2;
    localparam logic [2:0] KIND_STATUS_READ   = 3'd3;
    localparam logic [2:0] KIND_FRAME_TICK    = 3'd4;

    // Control byte and register bits.
    localparam logic [7:0] CTRL_REG_SELECT  = 8'h80;
    localparam logic [7:0] CTRL_NO_PREFETCH = 8'h40;
    localparam logic [7:0] IRQ_ENABLE_BIT   = 8'h20;
    localparam logic [7:0] STATUS_VBLANK    = 8'h80;
    localparam logic [7:0] STATUS_KEEP_MASK = 8'h1f;
    localparam logic [2:0] IRQ_CTRL_REG     = 3'd1;

    localparam logic [7:0] CTRL_MASK [8] = '{
        8'h03, 8'hfb, 8'h0f, 8'hff, 8'h07, 8'h7f, 8'h07, 8'hff
    };

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       interrupt_line;
    } out_item_t;

endpackage

// ===== hdl/vcp_vram.sv =====
// Video memory: single-port synchronous RAM with registered read data and a
// clearing sweep after reset. Depends on nothing but its parameters.
`timescale 1ns / 1ps

module vcp_vram #(
    parameter int MEMORY_BYTES = 16384,
    parameter int ADDR_W = 14
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] addr,
    input  logic [7:0]        wdata,
    output logic [7:0]        rdata,
    output logic              clearing
);

    logic [7:0]        mem [MEMORY_BYTES];
    logic [7:0]        rdata_reg;
    logic              clearing_reg;
    logic              clearing_next;
    logic [ADDR_W-1:0] clear_addr_reg;
    logic [ADDR_W-1:0] clear_addr_next;
    logic [ADDR_W-1:0] port_addr;
    logic [7:0]        port_wdata;
    logic              port_we;

    always_comb begin
        clearing_next   = clearing_reg;
        clear_addr_next = clear_addr_reg;
        if (clearing_reg) begin
            clear_addr_next = clear_addr_reg + ADDR_W'(1);
            if (clear_addr_reg == {ADDR_W{1'b1}}) begin
                clearing_next = 1'b0;
            end
        end
    end

    // The sweep owns the port until every entry holds zero.
    assign port_addr  = clearing_reg ? clear_addr_reg : addr;
    assign port_wdata = clearing_reg ? 8'h00 : wdata;
    assign port_we    = clearing_reg | wr_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg   <= 1'b1;
            clear_addr_reg <= '0;
        end else begin
            clearing_reg   <= clearing_next;
            clear_addr_reg <= clear_addr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (port_we) begin
            mem[port_addr] <= port_wdata;
        end
        rdata_reg <= mem[port_addr];
    end

    assign rdata    = rdata_reg;
    assign clearing = clearing_reg;

endmodule

// ===== hdl/vcp_core.sv =====
// Port state and transaction decode: pointer, latch, interrupt control,
// status and read-ahead byte. Depends on vcp_pkg; drives vcp_vram.
`timescale 1ns / 1ps

module vcp_core #(
    parameter int ADDR_W = 14
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               accept,
    input  vcp_pkg::in_item_t  item,
    output vcp_pkg::out_item_t result,
    output logic               mem_wr_en,
    output logic [ADDR_W-1:0]  mem_addr,
    output logic [7:0]         mem_wdata,
    input  logic [7:0]         mem_rdata
);

    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic [7:0]        prefetch_reg, prefetch_next;
    logic              pf_mem_reg, pf_mem_next;
    logic              latch_full_reg, latch_full_next;
    logic [7:0]        latch_byte_reg, latch_byte_next;
    logic [7:0]        irq_ctrl_reg, irq_ctrl_next;
    logic [7:0]        status_reg, status_next;
    logic              irq_reg, irq_next;
    logic [7:0]        pf_cur;
    logic [7:0]        masked;
    logic [15:0]       set_addr;
    logic [2:0]        reg_idx;

    // Only the register that holds the interrupt enable affects this port;
    // writes to the others are not held in this block.
    assign pf_cur   = pf_mem_reg ? mem_rdata : prefetch_reg;
    assign reg_idx  = item.data_byte[2:0];
    assign masked   = latch_byte_reg & vcp_pkg::CTRL_MASK[reg_idx];
    assign set_addr = {item.data_byte, latch_byte_reg};

    always_comb begin
        ptr_next        = ptr_reg;
        prefetch_next   = pf_cur;
        pf_mem_next     = 1'b0;
        latch_full_next = latch_full_reg;
        latch_byte_next = latch_byte_reg;
        irq_ctrl_next   = irq_ctrl_reg;
        status_next     = status_reg;
        irq_next        = irq_reg;
        mem_wr_en       = 1'b0;
        mem_addr        = ptr_reg;
        mem_wdata       = item.data_byte;
        result.read_data = 8'h00;
        if (accept) begin
            case (item.kind)
                vcp_pkg::KIND_DATA_WRITE: begin
                    mem_wr_en       = 1'b1;
                    ptr_next        = ptr_reg + ADDR_W'(1);
                    prefetch_next   = item.data_byte;
                    latch_full_next = 1'b0;
                end
                vcp_pkg::KIND_CONTROL_WRITE: begin
                    if (!latch_full_reg) begin
                        latch_byte_next = item.data_byte;
                        latch_full_next = 1'b1;
                    end else begin
                        latch_full_next = 1'b0;
                        if ((item.data_byte & vcp_pkg::CTRL_REG_SELECT) != 8'h00) begin
                            if (reg_idx == vcp_pkg::IRQ_CTRL_REG) begin
                                irq_ctrl_next = masked;
                                if (masked != irq_ctrl_reg
                                    && (masked & vcp_pkg::IRQ_ENABLE_BIT) != 8'h00
                                    && (status_reg & vcp_pkg::STATUS_VBLANK) != 8'h00) begin
                                    irq_next = 1'b1;
                                end
                            end
                        end else begin
                            ptr_next = set_addr[ADDR_W-1:0];
                            if ((item.data_byte & vcp_pkg::CTRL_NO_PREFETCH) == 8'h00) begin
                                mem_addr    = set_addr[ADDR_W-1:0];
                                pf_mem_next = 1'b1;
                                ptr_next    = set_addr[ADDR_W-1:0] + ADDR_W'(1);
                            end
                        end
                    end
                end
                vcp_pkg::KIND_DATA_READ: begin
                    result.read_data = pf_cur;
                    pf_mem_next      = 1'b1;
                    ptr_next         = ptr_reg + ADDR_W'(1);
                    latch_full_next  = 1'b0;
                end
                vcp_pkg::KIND_STATUS_READ: begin
                    result.read_data = status_reg;
                    status_next      = status_reg & vcp_pkg::STATUS_KEEP_MASK;
                    latch_full_next  = 1'b0;
                    irq_next         = 1'b0;
                end
                vcp_pkg::KIND_FRAME_TICK: begin
                    status_next = status_reg | vcp_pkg::STATUS_VBLANK;
                    if ((irq_ctrl_reg & vcp_pkg::IRQ_ENABLE_BIT) != 8'h00) begin
                        irq_next = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        result.interrupt_line = irq_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg        <= '0;
            prefetch_reg   <= 8'h00;
            pf_mem_reg     <= 1'b0;
            latch_full_reg <= 1'b0;
            latch_byte_reg <= 8'h00;
            irq_ctrl_reg   <= 8'h00;
            status_reg     <= 8'h00;
            irq_reg        <= 1'b0;
        end else begin
            ptr_reg        <= ptr_next;
            prefetch_reg   <= prefetch_next;
            pf_mem_reg     <= pf_mem_next;
            latch_full_reg <= latch_full_next;
            latch_byte_reg <= latch_byte_next;
            irq_ctrl_reg   <= irq_ctrl_next;
            status_reg     <= status_next;
            irq_reg        <= irq_next;
        end
    end

`ifndef SYNTHESIS
    a_status_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && item.kind == vcp_pkg::KIND_STATUS_READ
        |=> status_reg[7:5] == 3'b000 && !irq_reg)
        else $error("status read did not clear status bits and interrupt");

    a_tick_sets_vblank: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && item.kind == vcp_pkg::KIND_FRAME_TICK |=> status_reg[7])
        else $error("frame tick did not set vertical blank");

    a_write_prefetch: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && item.kind == vcp_pkg::KIND_DATA_WRITE
        |=> !pf_mem_reg && prefetch_reg == $past(item.data_byte))
        else $error("data write did not load the read-ahead byte");

    a_read_fetches: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && item.kind == vcp_pkg::KIND_DATA_READ
        |=> pf_mem_reg && ptr_reg == $past(ptr_reg) + ADDR_W'(1))
        else $error("data read did not start a fetch and advance the pointer");
`endif

endmodule

// ===== hdl/vcp_obuf.sv =====
// Two-entry result buffer between the port logic and the result channel.
// Depends on vcp_pkg.
`timescale 1ns / 1ps

module vcp_obuf (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  vcp_pkg::out_item_t push_data,
    output logic               has_space,
    output logic               m_valid,
    input  logic               m_ready,
    output vcp_pkg::out_item_t m_data
);

    vcp_pkg::out_item_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign pop       = m_valid && m_ready;
    assign has_space = (count_reg != 2'd2);
    assign m_valid   = (count_reg != 2'd0);
    assign m_data    = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hdl/video_chip_cpu_port_interface.sv =====
// Top level of the video chip CPU port. Instantiates vcp_vram, vcp_core and
// vcp_obuf; uses vcp_pkg.
//
//   Channel   Ports                         Payload
//   input     s_valid, s_ready, s_data      kind, data_byte
//   result    m_valid, m_ready, m_data      read_data, interrupt_line
//
// One transaction per cycle while s_ready is high; each result is registered in a
// two-entry result buffer and leaves it in order. The video memory has a single port
// and each transaction uses it at most once, so reads, writes and prefetches
// never collide. After reset, a clearing sweep writes zero to every memory
// byte, with s_ready low while it runs. s_ready also drops while the result
// buffer holds two results.
`timescale 1ns / 1ps

module video_chip_cpu_port_interface #(
    parameter int MEMORY_BYTES = vcp_pkg::DEFAULT_MEMORY_BYTES
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  vcp_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output vcp_pkg::out_item_t m_data
);

    localparam int ADDR_W = $clog2(MEMORY_BYTES);

    logic               accept;
    logic               clearing;
    logic               has_space;
    logic               mem_wr_en;
    logic [ADDR_W-1:0]  mem_addr;
    logic [7:0]         mem_wdata;
    logic [7:0]         mem_rdata;
    vcp_pkg::out_item_t result;

    assign s_ready = !clearing && has_space;
    assign accept  = s_valid && s_ready;

    vcp_vram #(
        .MEMORY_BYTES(MEMORY_BYTES),
        .ADDR_W      (ADDR_W)
    ) u_vram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (mem_wr_en),
        .addr    (mem_addr),
        .wdata   (mem_wdata),
        .rdata   (mem_rdata),
        .clearing(clearing)
    );

    vcp_core #(
        .ADDR_W(ADDR_W)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .item     (s_data),
        .result   (result),
        .mem_wr_en(mem_wr_en),
        .mem_addr (mem_addr),
        .mem_wdata(mem_wdata),
        .mem_rdata(mem_rdata)
    );

    vcp_obuf u_obuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (accept),
        .push_data(result),
        .has_space(has_space),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the video chip CPU port: a directed table, checked against results
// in its rows or a bench shadow of the port state, then random traffic checked against it.
// Depends on vcp_pkg and video_chip_cpu_port_interface.
`timescale 1ns / 1ps

module tb_top;

    localparam int          MEM_BYTES    = vcp_pkg::DEFAULT_MEMORY_BYTES;
    localparam int unsigned ADDR_MASK    = MEM_BYTES - 1;
    localparam logic [2:0]  KIND_SPARE   = 3'd7;
    localparam bit          CHECK_FIXED  = 1'b1;
    localparam bit          CHECK_PREDICTED = 1'b0;
    localparam int          ITEM_TARGET  = 950;
    localparam int          DRAIN_CYCLES = 20;
    // The limit covers the clearing sweep, with room to spare for the traffic.
    localparam int          CYCLE_LIMIT  = 400000;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    vcp_pkg::in_item_t  s_data = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    vcp_pkg::out_item_t m_data;

    video_chip_cpu_port_interface #(.MEMORY_BYTES(MEM_BYTES)) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Shadow of the port state.
    bit [7:0]    vram_shadow [MEM_BYTES];
    int unsigned addr_ptr;
    bit [7:0]    read_ahead;
    bit          latch_held;
    bit [7:0]    latch_lo;
    bit [7:0]    ctrl_regs [8];
    bit [7:0]    status_reg;
    bit          irq_level;

    vcp_pkg::out_item_t expected_results [$];
    int          mismatch_count = 0;
    int          sent_count = 0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          cycle_count = 0;

    function automatic bit [7:0] take_read_ahead();
        bit [7:0] old;
        old = read_ahead;
        read_ahead = vram_shadow[addr_ptr];
        addr_ptr = (addr_ptr + 1) & ADDR_MASK;
        latch_held = 1'b0;
        return old;
    endfunction

    function automatic vcp_pkg::out_item_t predict_port_access(input vcp_pkg::in_item_t item);
        vcp_pkg::out_item_t res;
        bit [2:0]  sel;
        bit [7:0]  masked;
        res = '0;
        case (item.kind)
            vcp_pkg::KIND_DATA_WRITE: begin
                vram_shadow[addr_ptr] = item.data_byte;
                addr_ptr = (addr_ptr + 1) & ADDR_MASK;
                read_ahead = item.data_byte;
                latch_held = 1'b0;
            end
            vcp_pkg::KIND_CONTROL_WRITE: begin
                if (!latch_held) begin
                    latch_lo = item.data_byte;
                    latch_held = 1'b1;
                end else begin
                    latch_held = 1'b0;
                    if ((item.data_byte & vcp_pkg::CTRL_REG_SELECT) != 0) begin
                        sel = item.data_byte[2:0];
                        masked = latch_lo & vcp_pkg::CTRL_MASK[sel];
                        // Rewriting the same value must not raise the interrupt again.
                        if (masked != ctrl_regs[sel]) begin
                            ctrl_regs[sel] = masked;
                            if (sel == vcp_pkg::IRQ_CTRL_REG &&
                                (masked & vcp_pkg::IRQ_ENABLE_BIT) != 0 &&
                                (status_reg & vcp_pkg::STATUS_VBLANK) != 0)
                                irq_level = 1'b1;
                        end
                    end else begin
                        addr_ptr = {item.data_byte, latch_lo} & ADDR_MASK;
                        if ((item.data_byte & vcp_pkg::CTRL_NO_PREFETCH) == 0)
                            void'(take_read_ahead());
                    end
                end
            end
            vcp_pkg::KIND_DATA_READ: begin
                res.read_data = take_read_ahead();
            end
            vcp_pkg::KIND_STATUS_READ: begin
                res.read_data = status_reg;
                status_reg = status_reg & vcp_pkg::STATUS_KEEP_MASK;
                latch_held = 1'b0;
                irq_level = 1'b0;
            end
            vcp_pkg::KIND_FRAME_TICK: begin
                status_reg = status_reg | vcp_pkg::STATUS_VBLANK;
                if ((ctrl_regs[vcp_pkg::IRQ_CTRL_REG] & vcp_pkg::IRQ_ENABLE_BIT) != 0)
                    irq_level = 1'b1;
            end
            default: ;
        endcase
        res.interrupt_line = irq_level;
        return res;
    endfunction

    // Drives one transaction and records its expected result once it is accepted.
    // Valid is left high on return so that a following transaction can go out back to back.
    task automatic send_item(input logic [2:0] kind, input logic [7:0] data_byte,
                             input bit fixed_want, input vcp_pkg::out_item_t want);
        vcp_pkg::in_item_t  item;
        vcp_pkg::out_item_t predicted;
        item.kind = kind;
        item.data_byte = data_byte;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        predicted = predict_port_access(item);
        expected_results.push_back(fixed_want ? want : predicted);
        sent_count++;
    endtask

    task automatic send(input logic [2:0] kind, input logic [7:0] data_byte);
        send_item(kind, data_byte, CHECK_PREDICTED, '0);
    endtask

    function automatic logic [5:0] pick_page();
        // Mostly the two lowest pages, so that reads land on bytes written earlier.
        if ($urandom_range(3) == 0)
            return 6'($urandom_range(63));
        return 6'($urandom_range(1));
    endfunction

    task automatic random_burst();
        int         choice;
        int         count;
        logic [7:0] lo;
        choice = $urandom_range(99);
        count  = $urandom_range(1, 6);
        lo = ($urandom_range(2) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(31));
        if (choice < 30) begin
            send(vcp_pkg::KIND_CONTROL_WRITE, lo);
            send(vcp_pkg::KIND_CONTROL_WRITE, {2'b01, pick_page()});
            repeat (count) send(vcp_pkg::KIND_DATA_WRITE, 8'($urandom_range(255)));
        end else if (choice < 55) begin
            send(vcp_pkg::KIND_CONTROL_WRITE, lo);
            send(vcp_pkg::KIND_CONTROL_WRITE, {2'b00, pick_page()});
            repeat (count) send(vcp_pkg::KIND_DATA_READ, 8'($urandom_range(255)));
        end else if (choice < 75) begin
            send(vcp_pkg::KIND_CONTROL_WRITE, 8'($urandom_range(255)));
            send(vcp_pkg::KIND_CONTROL_WRITE,
                 vcp_pkg::CTRL_REG_SELECT | 8'($urandom_range(127)));
        end else if (choice < 88) begin
            send($urandom_range(1) ? vcp_pkg::KIND_FRAME_TICK : vcp_pkg::KIND_STATUS_READ,
                 8'($urandom_range(255)));
        end else begin
            // Noise: any kind, including the unused ones and half-finished control pairs.
            repeat ($urandom_range(1, 3))
                send(3'($urandom_range(7)), 8'($urandom_range(255)));
        end
    endtask

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data_byte;
        logic       fixed_want;
        logic [7:0] want_data;
        logic       want_irq;
    } directed_row_t;

    localparam int NUM_DIRECTED = 26;

    directed_row_t directed_rows [NUM_DIRECTED] = '{
        '{vcp_pkg::KIND_STATUS_READ,   8'h00, CHECK_FIXED,     8'h00, 1'b0},
        '{vcp_pkg::KIND_DATA_READ,     8'hff, CHECK_FIXED,     8'h00, 1'b0},
        '{vcp_pkg::KIND_FRAME_TICK,    8'h00, CHECK_FIXED,     8'h00, 1'b0},
        '{vcp_pkg::KIND_STATUS_READ,   8'h00, CHECK_FIXED,     8'h80, 1'b0},
        '{vcp_pkg::KIND_CONTROL_WRITE, 8'hff, CHECK_FIXED,     8'h00, 1'b0},
        '{vcp_pkg::KIND_CONTROL_WRITE, 8'h81, CHECK_FIXED,     8'h00, 1'b0},
        '{vcp_pkg::KIND_FRAME_TICK,    8'h00, CHECK_FIXED,     8'h00, 1'b1},
        '{vcp_pkg::KIND_STATUS_READ,   8'h00, CHECK_FIXED,     8'h80, 1'b0},
        '{vcp_pkg::KIND_FRAME_TICK,    8'h00, CHECK_FIXED,     8'h00, 1'b1},
        // Disabling the interrupt leaves a pending one in place.
        '{vcp_pkg::KIND_CONTROL_WRITE, 8'h00, CHECK_FIXED,     8'h00, 1'b1},
        '{vcp_pkg::KIND_CONTROL_WRITE, 8'h81, CHECK_FIXED,     8'h00, 1'b1},
        '{vcp_pkg::KIND_STATUS_READ,   8'h00, CHECK_FIXED,     8'h80, 1'b0},
        // Blanking with the interrupt off, then enabling it, raises the line.
        '{vcp_pkg::KIND_FRAME_TICK,    8'h00, CHECK_FIXED,     8'h00, 1'b0},
        '{vcp_pkg::KIND_CONTROL_WRITE, 8'h20, CHECK_FIXED,     8'h00, 1'b0},
        '{vcp_pkg::KIND_CONTROL_WRITE, 8'h81, CHECK_FIXED,     8'h00, 1'b1},
        // Top address without prefetch; writes wrap the pointer to zero.
        '{vcp_pkg::KIND_CONTROL_WRITE, 8'hff, CHECK_FIXED,     8'h00, 1'b1},
        '{vcp_pkg::KIND_CONTROL_WRITE, 8'h7f, CHECK_FIXED,     8'h00, 1'b1},
        '{vcp_pkg::KIND_DATA_WRITE,    8'ha5, CHECK_PREDICTED, 8'h00, 1'b0},
        '{vcp_pkg::KIND_DATA_WRITE,    8'h5a, CHECK_PREDICTED, 8'h00, 1'b0},
        '{vcp_pkg::KIND_CONTROL_WRITE, 8'hff, CHECK_PREDICTED, 8'h00, 1'b0},
        '{vcp_pkg::KIND_CONTROL_WRITE, 8'h3f, CHECK_PREDICTED, 8'h00, 1'b0},
        '{vcp_pkg::KIND_DATA_READ,     8'h00, CHECK_FIXED,     8'ha5, 1'b1},
        '{vcp_pkg::KIND_DATA_READ,     8'h00, CHECK_FIXED,     8'h5a, 1'b1},
        '{KIND_SPARE,                  8'hff, CHECK_FIXED,     8'h00, 1'b1},
        // A status read in the middle of a control pair empties the latch.
        '{vcp_pkg::KIND_CONTROL_WRITE, 8'h5c, CHECK_PREDICTED, 8'h00, 1'b0},
        '{vcp_pkg::KIND_STATUS_READ,   8'h00, CHECK_FIXED,     8'h80, 1'b0}
    };

    always @(posedge aclk) begin : result_check
        vcp_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result: read_data %h interrupt_line %b",
                         $time, m_data.read_data, m_data.interrupt_line);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                if (m_data.read_data !== want.read_data) begin
                    $display("%0t: read_data expected %h actual %h",
                             $time, want.read_data, m_data.read_data);
                    mismatch_count++;
                end
                if (m_data.interrupt_line !== want.interrupt_line) begin
                    $display("%0t: interrupt_line expected %b actual %b",
                             $time, want.interrupt_line, m_data.interrupt_line);
                    mismatch_count++;
                end
            end
        end
        m_ready <= aresetn && ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i].kind, directed_rows[i].data_byte,
                      directed_rows[i].fixed_want,
                      '{read_data: directed_rows[i].want_data,
                        interrupt_line: directed_rows[i].want_irq});

        while (sent_count < ITEM_TARGET) begin
            case ((sent_count - NUM_DIRECTED) * 4 / (ITEM_TARGET - NUM_DIRECTED))
                0: begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 51;
                    stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct = 51;
                end
                default: begin
                    send_idle_pct = 27;
                    stall_pct = 27;
                end
            endcase
            random_burst();
        end
        s_valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
